[rtl/fspf_pkg.sv]
// Shared constants for the filtered sample packet framer.
// Used by the top level; no dependencies.
package fspf_pkg;

    localparam int WINDOW_SIZE_DEF = 5;
    localparam int SAMPLE_W        = 12;
    localparam int BYTE_W          = 8;
    localparam int FRAME_LEN       = 8;
    localparam int BIDX_W          = 3;

    localparam logic [BYTE_W-1:0] SYNC_BYTE    = 8'hAA;
    localparam logic [BYTE_W-1:0] VERSION_BYTE = 8'h01;
    localparam logic [BYTE_W-1:0] KIND_BYTE    = 8'h02;
    localparam logic [BYTE_W-1:0] END_BYTE     = 8'hCC;

    // byte positions inside a frame
    localparam logic [BIDX_W-1:0] BI_SYNC    = 3'd0;
    localparam logic [BIDX_W-1:0] BI_VERSION = 3'd1;
    localparam logic [BIDX_W-1:0] BI_KIND    = 3'd2;
    localparam logic [BIDX_W-1:0] BI_FILTER  = 3'd3;
    localparam logic [BIDX_W-1:0] BI_VAL_HI  = 3'd4;
    localparam logic [BIDX_W-1:0] BI_VAL_LO  = 3'd5;
    localparam logic [BIDX_W-1:0] BI_CSUM    = 3'd6;
    localparam logic [BIDX_W-1:0] BI_END     = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

endpackage

[rtl/fspf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fspf_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 5,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/filtered_sample_packet_framer.sv]
// Sample framer top level: button-controlled averaging filter and frame output.
// Depends on fspf_pkg and fspf_ram.
//
// Each request carries a button level and optionally a 12-bit sample. A falling
// button edge toggles filter mode, and turning the filter on restarts the window.
// Every sample is written to a WINDOW_SIZE-entry window RAM and produces one
// 8-byte frame (AA 01 02 F VH VL S CC, last byte flagged on m_tlast). A request
// without a sample produces no frame. With the filter off a sample goes straight
// to the frame output. With the filter on, N window entries are first read back
// one per cycle from the RAM and summed, where N is the number of entries held
// (at most WINDOW_SIZE), and the sum is then divided by N in a bit-serial divider
// of SUM_W = 12 + clog2(WINDOW_SIZE) steps to form the mean. Frame bytes are
// held while m_tready is low.
module filtered_sample_packet_framer
    import fspf_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [0] button_level, [12:1] sample, rest zero
    input  logic        s_tuser,   // [0] sample_valid
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast    // frame_last
);

    localparam int POS_W  = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);
    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_SIZE);
    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [POS_W:0]    WIN_P = (POS_W + 1)'(WINDOW_SIZE);
    localparam logic [CNT_W-1:0]  WIN_C = CNT_W'(WINDOW_SIZE);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

    state_t               state_reg, state_next;
    logic                 prev_btn_reg, prev_btn_next;
    logic                 filt_reg, filt_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic                 full_reg, full_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 rd_vld_reg, rd_vld_next;
    logic [SUM_W-1:0]     acc_reg, acc_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [SUM_W-1:0]     quo_reg, quo_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [SAMPLE_W-1:0]  value_reg, value_next;
    logic [BIDX_W-1:0]    bidx_reg, bidx_next;

    logic                 in_btn;
    logic                 in_vld;
    logic [SAMPLE_W-1:0]  in_sample;
    logic                 s_acc;
    logic                 btn_fall;
    logic                 restart;
    logic [POS_W-1:0]     pos_base;
    logic                 full_base;
    logic [POS_W:0]       pos_inc;
    logic                 wrap;
    logic [POS_W-1:0]     pos_after;
    logic                 full_after;

    logic                 ram_we;
    logic                 ram_re;
    logic [SAMPLE_W-1:0]  ram_rdata;
    logic [SUM_W-1:0]     acc_sum;
    logic [CNT_W:0]       trial;
    logic [CNT_W:0]       trial_sub;
    logic                 trial_ge;
    logic [BYTE_W-1:0]    csum;

    assign in_btn    = s_tdata[0];
    assign in_sample = s_tdata[12:1];
    assign in_vld    = s_tuser;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    // button edge first, then the sample goes into the window
    assign btn_fall  = prev_btn_reg && !in_btn;
    assign restart   = btn_fall && !filt_reg;
    assign pos_base  = restart ? '0 : pos_reg;
    assign full_base = restart ? 1'b0 : full_reg;
    assign pos_inc   = {1'b0, pos_base} + 1'b1;
    assign wrap      = (pos_inc == WIN_P);
    assign pos_after = wrap ? '0 : pos_inc[POS_W-1:0];
    assign full_after = full_base || wrap;

    assign ram_we = s_acc && in_vld;
    assign ram_re = (state_reg == ST_READ) && (rd_idx_reg < cnt_reg);

    // reads start the cycle after the write commits, so no forwarding is needed
    fspf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_SIZE),
        .ADDR_W(POS_W)
    ) u_window (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (pos_base),
        .wdata (in_sample),
        .re    (ram_re),
        .raddr (rd_idx_reg[POS_W-1:0]),
        .rdata (ram_rdata)
    );

    assign acc_sum   = acc_reg + (rd_vld_reg ? SUM_W'(ram_rdata) : '0);

    // restoring divide, one quotient bit per cycle
    assign trial     = {rem_reg, quo_reg[SUM_W-1]};
    assign trial_ge  = (trial >= {1'b0, cnt_reg});
    assign trial_sub = trial - {1'b0, cnt_reg};

    always_comb begin
        state_next    = state_reg;
        prev_btn_next = prev_btn_reg;
        filt_next     = filt_reg;
        pos_next      = pos_reg;
        full_next     = full_reg;
        cnt_next      = cnt_reg;
        rd_idx_next   = rd_idx_reg;
        rd_vld_next   = rd_vld_reg;
        acc_next      = acc_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        step_next     = step_reg;
        value_next    = value_reg;
        bidx_next     = bidx_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    prev_btn_next = in_btn;
                    filt_next     = filt_reg ^ btn_fall;
                    pos_next      = pos_base;
                    full_next     = full_base;
                    if (in_vld) begin
                        pos_next    = pos_after;
                        full_next   = full_after;
                        cnt_next    = full_after ? WIN_C : CNT_W'(pos_after);
                        rd_idx_next = '0;
                        rd_vld_next = 1'b0;
                        acc_next    = '0;
                        value_next  = in_sample;
                        bidx_next   = BI_SYNC;
                        state_next  = (filt_reg ^ btn_fall) ? ST_READ : ST_EMIT;
                    end
                end
            end
            ST_READ: begin
                acc_next    = acc_sum;
                rd_vld_next = ram_re;
                if (ram_re) begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if ((rd_idx_reg == cnt_reg) && rd_vld_reg) begin
                    quo_next   = acc_sum;
                    rem_next   = '0;
                    step_next  = STEP_LAST;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (trial_ge) begin
                    rem_next = trial_sub[CNT_W-1:0];
                    quo_next = {quo_reg[SUM_W-2:0], 1'b1};
                end else begin
                    rem_next = trial[CNT_W-1:0];
                    quo_next = {quo_reg[SUM_W-2:0], 1'b0};
                end
                step_next = step_reg - 1'b1;
                if (step_reg == '0) begin
                    // mean of 12-bit entries never exceeds 12 bits
                    value_next = quo_next[SAMPLE_W-1:0];
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (m_tready) begin
                    bidx_next = bidx_reg + 1'b1;
                    if (bidx_reg == BI_END) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            prev_btn_reg <= 1'b1;
            filt_reg     <= 1'b0;
            pos_reg      <= '0;
            full_reg     <= 1'b0;
            rd_vld_reg   <= 1'b0;
            bidx_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            prev_btn_reg <= prev_btn_next;
            filt_reg     <= filt_next;
            pos_reg      <= pos_next;
            full_reg     <= full_next;
            rd_vld_reg   <= rd_vld_next;
            bidx_reg     <= bidx_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg    <= cnt_next;
        rd_idx_reg <= rd_idx_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        step_reg   <= step_next;
        value_reg  <= value_next;
    end

    assign csum = VERSION_BYTE + KIND_BYTE + {7'd0, filt_reg}
                + {4'd0, value_reg[11:8]} + value_reg[7:0];

    always_comb begin
        case (bidx_reg)
            BI_SYNC:    m_tdata = SYNC_BYTE;
            BI_VERSION: m_tdata = VERSION_BYTE;
            BI_KIND:    m_tdata = KIND_BYTE;
            BI_FILTER:  m_tdata = {7'd0, filt_reg};
            BI_VAL_HI:  m_tdata = {4'd0, value_reg[11:8]};
            BI_VAL_LO:  m_tdata = value_reg[7:0];
            BI_CSUM:    m_tdata = csum;
            BI_END:     m_tdata = END_BYTE;
            default:    m_tdata = END_BYTE;
        endcase
    end

    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tlast  = (bidx_reg == BI_END);

endmodule
